// ===== hdl/affine_box_transform_defines.svh =====
// Assertion macros for the affine box transform block.
// Used by the top level only; relies on clk and arst_n being in scope.
`ifndef AFFINE_BOX_TRANSFORM_DEFINES_SVH
`define AFFINE_BOX_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/abt_pkg.sv =====
// Shared types, constants and saturation functions for the affine box transform.
// Used by every module of the block; has no dependencies.
package abt_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int MAT_W         = 32;
	localparam int PAIR_W        = 2 * MAT_W;
	localparam int NUM_PAIRS     = 6;
	localparam int NUM_ENTRIES   = 2 * NUM_PAIRS;
	localparam int NUM_AXES      = 3;
	localparam int ROW_STRIDE    = NUM_AXES + 1;
	localparam int CFG_IDX_W     = $clog2(NUM_PAIRS);
	localparam int PROD_W        = MAT_W + COORD_WIDTH;
	localparam int SHIFT_W       = PROD_W - FRACTION_BITS;
	localparam int SUM_W         = ((COORD_WIDTH > MAT_W) ? COORD_WIDTH : MAT_W) + 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [PAIR_W-1:0] pair_t;
	typedef logic [NUM_ENTRIES-1:0][MAT_W-1:0] entries_t;
	typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] vec_t;
	typedef logic [NUM_AXES-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] prod_grid_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIR_0 = CFG_IDX_W'(0),
		REG_PAIR_1 = CFG_IDX_W'(1),
		REG_PAIR_2 = CFG_IDX_W'(2),
		REG_PAIR_3 = CFG_IDX_W'(3),
		REG_PAIR_4 = CFG_IDX_W'(4),
		REG_PAIR_5 = CFG_IDX_W'(5)
	} cfg_reg_t;

	// Identity matrix with zero translation.
	localparam pair_t PAIR_0_RESET = pair_t'(65536);
	localparam pair_t PAIR_1_RESET = '0;
	localparam pair_t PAIR_2_RESET = pair_t'(65536) << MAT_W;
	localparam pair_t PAIR_3_RESET = '0;
	localparam pair_t PAIR_4_RESET = '0;
	localparam pair_t PAIR_5_RESET = pair_t'(65536);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Saturate a floored product to the coordinate range.
	function automatic coord_t sat_shift(input logic signed [SHIFT_W-1:0] v);
		logic fits;
		fits = (v[SHIFT_W-1:COORD_WIDTH-1] == {(SHIFT_W-COORD_WIDTH+1){v[SHIFT_W-1]}});
		if (fits) begin
			return v[COORD_WIDTH-1:0];
		end else if (v[SHIFT_W-1]) begin
			return COORD_MIN;
		end else begin
			return COORD_MAX;
		end
	endfunction

	// Saturate a row sum to the coordinate range.
	function automatic coord_t sat_sum(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (v[SUM_W-1:COORD_WIDTH-1] == {(SUM_W-COORD_WIDTH+1){v[SUM_W-1]}});
		if (fits) begin
			return v[COORD_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			return COORD_MIN;
		end else begin
			return COORD_MAX;
		end
	endfunction

endpackage

// ===== hdl/abt_cfg_regs.sv =====
// Matrix configuration registers of the affine box transform.
// Depends on abt_pkg for widths, register codes and reset values.
module abt_cfg_regs
	import abt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAIR_W-1:0]    cfg_data,
	output entries_t             entries
);

	pair_t pair_q [NUM_PAIRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q[0] <= PAIR_0_RESET;
			pair_q[1] <= PAIR_1_RESET;
			pair_q[2] <= PAIR_2_RESET;
			pair_q[3] <= PAIR_3_RESET;
			pair_q[4] <= PAIR_4_RESET;
			pair_q[5] <= PAIR_5_RESET;
		end else if (cfg_valid) begin
			// Writes to unused indexes are dropped.
			unique case (cfg_reg_t'(cfg_index))
				REG_PAIR_0: pair_q[0] <= cfg_data;
				REG_PAIR_1: pair_q[1] <= cfg_data;
				REG_PAIR_2: pair_q[2] <= cfg_data;
				REG_PAIR_3: pair_q[3] <= cfg_data;
				REG_PAIR_4: pair_q[4] <= cfg_data;
				REG_PAIR_5: pair_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_PAIRS; k++) begin
			entries[2*k]   = pair_q[k][MAT_W-1:0];
			entries[2*k+1] = pair_q[k][PAIR_W-1:MAT_W];
		end
	end

endmodule

// ===== hdl/abt_mul_stage.sv =====
// Product stage: multiplies each linear matrix entry by the low and high
// coordinate of its axis, floors and saturates, and registers. Uses abt_pkg.
module abt_mul_stage
	import abt_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  entries_t   entries,
	input  vec_t       lo,
	input  vec_t       hi,
	output prod_grid_t prod_lo_s2,
	output prod_grid_t prod_hi_s2
);

	for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
		for (genvar a = 0; a < NUM_AXES; a++) begin : g_col
			logic signed [PROD_W-1:0] p_lo;
			logic signed [PROD_W-1:0] p_hi;

			assign p_lo = PROD_W'($signed(entries[ROW_STRIDE*r+a])) * PROD_W'($signed(lo[a]));
			assign p_hi = PROD_W'($signed(entries[ROW_STRIDE*r+a])) * PROD_W'($signed(hi[a]));

			// Dropping the fraction bits of a two's complement value floors it.
			always_ff @(posedge clk) begin
				if (en) begin
					prod_lo_s2[r][a] <= sat_shift(p_lo[PROD_W-1:FRACTION_BITS]);
					prod_hi_s2[r][a] <= sat_shift(p_hi[PROD_W-1:FRACTION_BITS]);
				end
			end
		end
	end

endmodule

// ===== hdl/abt_sum_stage.sv =====
// Bound stage: picks the smaller and larger product per term, adds the
// translation, saturates and registers the box. Uses abt_pkg.
module abt_sum_stage
	import abt_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  entries_t   entries,
	input  prod_grid_t prod_lo,
	input  prod_grid_t prod_hi,
	output vec_t       min_s3,
	output vec_t       max_s3
);

	logic signed [SUM_W-1:0] sum_min [NUM_AXES];
	logic signed [SUM_W-1:0] sum_max [NUM_AXES];

	// Every term is monotonic in its coordinate, so the extreme corner is
	// found term by term without visiting all eight corners.
	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			sum_min[r] = SUM_W'($signed(entries[ROW_STRIDE*r+NUM_AXES]));
			sum_max[r] = SUM_W'($signed(entries[ROW_STRIDE*r+NUM_AXES]));
			for (int a = 0; a < NUM_AXES; a++) begin
				if ($signed(prod_lo[r][a]) < $signed(prod_hi[r][a])) begin
					sum_min[r] = sum_min[r] + SUM_W'($signed(prod_lo[r][a]));
					sum_max[r] = sum_max[r] + SUM_W'($signed(prod_hi[r][a]));
				end else begin
					sum_min[r] = sum_min[r] + SUM_W'($signed(prod_hi[r][a]));
					sum_max[r] = sum_max[r] + SUM_W'($signed(prod_lo[r][a]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				min_s3[r] <= sat_sum(sum_min[r]);
				max_s3[r] <= sat_sum(sum_max[r]);
			end
		end
	end

endmodule

// ===== hdl/affine_box_transform.sv =====
// Top level of the affine box transform: registers, pipeline control, ports.
// Depends on abt_pkg, abt_cfg_regs, abt_mul_stage, abt_sum_stage and the defines header.
//
// Usage: one axis-aligned box enters per item on the input channel (in_valid,
// in_stall) and one transformed bounding box leaves per item on the output
// channel (out_valid, out_stall). An item moves when valid is high and stall
// is low. The 3x4 matrix is loaded through the configuration channel, six
// 64-bit registers each holding two Q16.16 entries; cfg_ready is always high
// and writes to indexes six and seven are ignored. Write the matrix only while
// no item is in flight.
// An item passes through an input register, a product register fed by
// eighteen parallel 32x32 multipliers, and the output register after the
// min/max selection and the saturating adds. Throughput is one item per cycle while
// the receiver does not stall; the multipliers are the deepest logic between registers.
// Reset clears the three stage valid bits and loads the identity matrix.
// When the receiver stalls, the output item holds; bubbles ahead of it are
// still filled, and in_stall rises only once all three stages are full.
`include "affine_box_transform_defines.svh"

module affine_box_transform
	import abt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [COORD_WIDTH-1:0] in_min_x,
	input  logic signed [COORD_WIDTH-1:0] in_min_y,
	input  logic signed [COORD_WIDTH-1:0] in_min_z,
	input  logic signed [COORD_WIDTH-1:0] in_max_x,
	input  logic signed [COORD_WIDTH-1:0] in_max_y,
	input  logic signed [COORD_WIDTH-1:0] in_max_z,
	// Output channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [COORD_WIDTH-1:0] out_min_x,
	output logic signed [COORD_WIDTH-1:0] out_min_y,
	output logic signed [COORD_WIDTH-1:0] out_min_z,
	output logic signed [COORD_WIDTH-1:0] out_max_x,
	output logic signed [COORD_WIDTH-1:0] out_max_y,
	output logic signed [COORD_WIDTH-1:0] out_max_z,
	// Configuration channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PAIR_W-1:0]     cfg_data
);

	entries_t   entries;
	vec_t       lo_s1;
	vec_t       hi_s1;
	prod_grid_t prod_lo_s2;
	prod_grid_t prod_hi_s2;
	vec_t       min_s3;
	vec_t       max_s3;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       adv_s1;
	logic       adv_s2;
	logic       adv_s3;

	// Configuration is always accepted; the registers feed the datapath directly, so the
	// user must change them only while the pipeline is empty; the block does not enforce it.
	assign cfg_ready = 1'b1;

	abt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.entries   (entries)
	);

	// A stage may load when it is empty or when its item moves on in the
	// same cycle. The output stage moves on when the receiver does not stall.
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Input register: the two box corners.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lo_s1 <= {in_min_z, in_min_y, in_min_x};
			hi_s1 <= {in_max_z, in_max_y, in_max_x};
		end
	end

	abt_mul_stage u_mul (
		.clk        (clk),
		.en         (adv_s2 && valid_s1),
		.entries    (entries),
		.lo         (lo_s1),
		.hi         (hi_s1),
		.prod_lo_s2 (prod_lo_s2),
		.prod_hi_s2 (prod_hi_s2)
	);

	abt_sum_stage u_sum (
		.clk     (clk),
		.en      (adv_s3 && valid_s2),
		.entries (entries),
		.prod_lo (prod_lo_s2),
		.prod_hi (prod_hi_s2),
		.min_s3  (min_s3),
		.max_s3  (max_s3)
	);

	assign out_valid = valid_s3;
	assign out_min_x = min_s3[0];
	assign out_min_y = min_s3[1];
	assign out_min_z = min_s3[2];
	assign out_max_x = max_s3[0];
	assign out_max_y = max_s3[1];
	assign out_max_z = max_s3[2];

	// The input side only waits when the output item is held.
	`ABT_ASSERT_IMP(a_no_stall_when_out_empty, !out_valid, !in_stall, "input stalled with empty output")

	// Per-term selection keeps every result box ordered.
	`ABT_ASSERT_IMP(a_box_ordered, out_valid, (out_min_x <= out_max_x) && (out_min_y <= out_max_y) && (out_min_z <= out_max_z), "result box minimum above maximum")

	// An item in the product stage reaches the output when it is free.
	`ABT_ASSERT_NXT(a_stage2_drains, valid_s2 && !out_stall, out_valid, "product stage item lost")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the affine box transform: a directed table, then random matrices
// and boxes with random idling on both channels. Depends on abt_pkg and affine_box_transform.
module tb_top;
	import abt_pkg::*;

	// A box as it crosses either data channel.
	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	// One row of the directed table. When typed is set, want holds the result that can be
	// read off by hand; otherwise the row is checked against the transform predictor.
	typedef struct packed {
		logic [2:0] setting;
		logic       typed;
		box_t       stim;
		box_t       want;
	} dir_row_t;

	// Matrix settings used by the directed table.
	localparam logic [2:0] SET_IDENTITY   = 3'd0;
	localparam logic [2:0] SET_ALL_MAX    = 3'd1;
	localparam logic [2:0] SET_ALL_MIN    = 3'd2;
	localparam logic [2:0] SET_ZERO       = 3'd3;
	localparam logic [2:0] SET_MIXED      = 3'd4;
	localparam logic [2:0] SET_MINUS_LSB  = 3'd5;

	// Register indexes past the last matrix pair; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = CFG_IDX_W'(7);

	localparam coord_t UNIT = 65536;

	// A permutation with scaling and translation: x' = -y + 2.5, y' = x - 3.0, z' = 0.5z + 0.75.
	localparam coord_t MIXED_ENTRIES [NUM_ENTRIES] = '{
		0, -65536, 0, 163840,
		65536, 0, 0, -196608,
		0, 0, 32768, 49152
	};

	localparam int NUM_DIRECTED    = 18;
	localparam int NUM_PHASES      = 14;
	localparam int ITEMS_PER_PHASE = 100;
	// Three pipeline stages plus margin before the matrix may change or the run may end.
	localparam int DRAIN_TAIL      = 6;
	// The longest correct quiet stretch is the long receiver hold-off plus a sender gap.
	localparam int LONG_HOLD       = 200;
	// Chosen well inside a random phase, so the sender still has items left to offer
	// when the hold-off begins.
	localparam int HOLD_AFTER      = 440;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic   clk;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   in_stall;
	coord_t in_min_x  = '0;
	coord_t in_min_y  = '0;
	coord_t in_min_z  = '0;
	coord_t in_max_x  = '0;
	coord_t in_max_y  = '0;
	coord_t in_max_z  = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t out_min_x;
	coord_t out_min_y;
	coord_t out_min_z;
	coord_t out_max_x;
	coord_t out_max_y;
	coord_t out_max_z;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	pair_t                cfg_data  = '0;

	// The testbench copy of the matrix registers, starting from their reset values.
	pair_t mat_mirror [NUM_PAIRS] = '{PAIR_0_RESET, PAIR_1_RESET, PAIR_2_RESET,
		PAIR_3_RESET, PAIR_4_RESET, PAIR_5_RESET};

	box_t     expected_boxes [$];
	box_t     oldest_box;
	dir_row_t directed_rows [NUM_DIRECTED];
	int       mismatches    = 0;
	int       results_seen  = 0;
	int       quiet_cycles  = 0;
	int       burst_left    = 0;

	affine_box_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_min_x  (in_min_x),
		.in_min_y  (in_min_y),
		.in_min_z  (in_min_z),
		.in_max_x  (in_max_x),
		.in_max_y  (in_max_y),
		.in_max_z  (in_max_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_min_x (out_min_x),
		.out_min_y (out_min_y),
		.out_min_z (out_min_z),
		.out_max_x (out_max_x),
		.out_max_y (out_max_y),
		.out_max_z (out_max_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------------------
	// Predictor. Matrix entry k sits in pair k/2, low word for even k and high word for odd.
	// ------------------------------------------------------------------------------------

	function automatic coord_t matrix_entry(int k);
		pair_t p;
		p = mat_mirror[k / 2];
		return coord_t'(p[(k % 2) * MAT_W +: MAT_W]);
	endfunction

	// The exact product, floored back to the coordinate's fraction, clamped to its range.
	function automatic coord_t scaled_product(coord_t m, coord_t v);
		logic signed [MAT_W+COORD_WIDTH-1:0] full;
		logic signed [MAT_W+COORD_WIDTH-FRACTION_BITS-1:0] floored;
		full = m * v;
		floored = full >>> FRACTION_BITS;
		if (floored > COORD_MAX) begin
			return COORD_MAX;
		end else if (floored < COORD_MIN) begin
			return COORD_MIN;
		end
		return coord_t'(floored);
	endfunction

	// One output axis of one corner: three products and the translation, summed without
	// loss and clamped once at the end.
	function automatic coord_t row_value(int r, coord_t x, coord_t y, coord_t z);
		logic signed [COORD_WIDTH+1:0] acc;
		acc = scaled_product(matrix_entry(4 * r), x) + scaled_product(matrix_entry(4 * r + 1), y)
			+ scaled_product(matrix_entry(4 * r + 2), z) + matrix_entry(4 * r + 3);
		if (acc > COORD_MAX) begin
			return COORD_MAX;
		end else if (acc < COORD_MIN) begin
			return COORD_MIN;
		end
		return coord_t'(acc);
	endfunction

	// Bounding box of the eight transformed corners. A box whose minimum lies above its
	// maximum is not special: its corners are transformed all the same.
	function automatic box_t transform_box(box_t b);
		coord_t lo [NUM_AXES];
		coord_t hi [NUM_AXES];
		coord_t pt [NUM_AXES];
		coord_t lo_out [NUM_AXES];
		coord_t hi_out [NUM_AXES];
		coord_t s;
		box_t   res;
		lo[0] = b.min_x;
		lo[1] = b.min_y;
		lo[2] = b.min_z;
		hi[0] = b.max_x;
		hi[1] = b.max_y;
		hi[2] = b.max_z;
		for (int c = 0; c < 8; c++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pt[a] = ((c >> a) & 1) != 0 ? hi[a] : lo[a];
			end
			for (int r = 0; r < NUM_AXES; r++) begin
				s = row_value(r, pt[0], pt[1], pt[2]);
				if (c == 0 || s < lo_out[r]) begin
					lo_out[r] = s;
				end
				if (c == 0 || s > hi_out[r]) begin
					hi_out[r] = s;
				end
			end
		end
		res.min_x = lo_out[0];
		res.min_y = lo_out[1];
		res.min_z = lo_out[2];
		res.max_x = hi_out[0];
		res.max_y = hi_out[1];
		res.max_z = hi_out[2];
		return res;
	endfunction

	// ------------------------------------------------------------------------------------
	// Random values.
	// ------------------------------------------------------------------------------------

	// Coordinates mix the range ends, zero, the smallest steps, values of moderate size
	// where products rarely clamp, and fully random words.
	function automatic coord_t random_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return ($urandom_range(0, 1) != 0) ? coord_t'(1) : coord_t'(-1);
			3: return '0;
			4, 5, 6: return coord_t'($urandom_range(0, 1 << 21)) - coord_t'(1 << 20);
			default: return coord_t'($urandom());
		endcase
	endfunction

	// Most boxes are well formed; the rest keep whatever order the corners came in.
	function automatic box_t random_box();
		box_t   b;
		coord_t t;
		b = {random_coord(), random_coord(), random_coord(),
			random_coord(), random_coord(), random_coord()};
		if ($urandom_range(0, 4) != 0) begin
			if (b.min_x > b.max_x) begin
				t = b.min_x;
				b.min_x = b.max_x;
				b.max_x = t;
			end
			if (b.min_y > b.max_y) begin
				t = b.min_y;
				b.min_y = b.max_y;
				b.max_y = t;
			end
			if (b.min_z > b.max_z) begin
				t = b.min_z;
				b.min_z = b.max_z;
				b.max_z = t;
			end
		end
		return b;
	endfunction

	// ------------------------------------------------------------------------------------
	// Channel tasks. All of them are entered and left on a rising clock edge.
	// ------------------------------------------------------------------------------------

	// Writes one register and mirrors it once the write is taken. Indexes past the last
	// pair leave the mirror alone, as they must leave the block alone.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input pair_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_PAIR_5) begin
			mat_mirror[idx] = data;
		end
	endtask

	// Loads all six pairs, then throws a random word at one of the unused indexes.
	task automatic load_matrix(input coord_t ents [NUM_ENTRIES]);
		for (int k = 0; k < NUM_PAIRS; k++) begin
			cfg_write(cfg_reg_t'(k), {ents[2 * k + 1], ents[2 * k]});
		end
		cfg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
			{$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	task automatic load_directed(input logic [2:0] setting);
		coord_t ents [NUM_ENTRIES];
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			case (setting)
				SET_IDENTITY:  ents[k] = (k == 0 || k == 5 || k == 10) ? UNIT : '0;
				SET_ALL_MAX:   ents[k] = COORD_MAX;
				SET_ALL_MIN:   ents[k] = COORD_MIN;
				SET_MIXED:     ents[k] = MIXED_ENTRIES[k];
				SET_MINUS_LSB: ents[k] = coord_t'(-1);
				default:       ents[k] = '0;
			endcase
		end
		load_matrix(ents);
	endtask

	// Random matrices: sometimes the identity with a random offset, sometimes entries of
	// moderate size, otherwise the same mix that the coordinates use.
	task automatic load_random_matrix();
		coord_t ents [NUM_ENTRIES];
		int     style;
		style = $urandom_range(0, 3);
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			if (style == 0) begin
				ents[k] = (k % 4 == 3) ? random_coord() : ((k % 5 == 0) ? UNIT : '0);
			end else if (style == 1) begin
				ents[k] = coord_t'($urandom_range(0, 1 << 19)) - coord_t'(1 << 18);
			end else begin
				ents[k] = random_coord();
			end
		end
		load_matrix(ents);
	endtask

	// Offers one box and holds it until the block takes it.
	task automatic send_box(input box_t b);
		in_valid <= 1'b1;
		in_min_x <= b.min_x;
		in_min_y <= b.min_y;
		in_min_z <= b.min_z;
		in_max_x <= b.max_x;
		in_max_y <= b.max_y;
		in_max_z <= b.max_z;
		do @(posedge clk); while (in_stall);
	endtask

	// The sender works in bursts: mostly short ones, now and then a long run with no gap.
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Stops offering and waits until every outstanding box has come back, plus the
	// drain tail, so the matrix can be changed safely.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic check_coord(input string name, input coord_t want, input coord_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Output checking: every accepted result is compared with the oldest expectation.
	// ------------------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_boxes.size() == 0) begin
				$error("result arrived with no item outstanding");
				mismatches++;
			end else begin
				oldest_box = expected_boxes.pop_front();
				check_coord("out_min_x", oldest_box.min_x, out_min_x);
				check_coord("out_min_y", oldest_box.min_y, out_min_y);
				check_coord("out_min_z", oldest_box.min_z, out_min_z);
				check_coord("out_max_x", oldest_box.max_x, out_max_x);
				check_coord("out_max_y", oldest_box.max_y, out_max_y);
				check_coord("out_max_z", oldest_box.max_z, out_max_z);
			end
		end
	end

	// The watchdog ends the run once no channel has moved anything for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------------------
	// Receiver. Stretches of random length alternate between no stall, light stall and
	// heavy stall. Once, after a few hundred results, the receiver holds off for a long
	// stretch while the sender keeps offering, so the pipeline fills and in_stall rises.
	// ------------------------------------------------------------------------------------

	initial begin
		bit held_off;
		int stall_pct;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
			end
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 25;
				default: stall_pct = 60;
			endcase
			repeat ($urandom_range(10, 60)) begin
				@(posedge clk);
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Sender: reset, the directed table, then random phases, each under a fresh matrix.
	// ------------------------------------------------------------------------------------

	initial begin
		logic [2:0] setting_now;
		box_t       b;

		// The identity rows check extremes and an inverted box by hand. The saturating
		// settings check that products and sums clamp at both ends. The last setting,
		// every entry one step below zero, shows that products round toward minus
		// infinity: a product of -1 and 1 step gives -1 step, not zero.
		directed_rows = '{
			'{SET_IDENTITY, 1'b1, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
			'{SET_IDENTITY, 1'b1,
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_IDENTITY, 1'b1,
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_IDENTITY, 1'b1, '{-1, -1, -1, -1, -1, -1}, '{-1, -1, -1, -1, -1, -1}},
			'{SET_IDENTITY, 1'b0, '{-98304, 32768, -7, 163840, 65536, 7}, '0},
			'{SET_ALL_MAX, 1'b1,
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_ALL_MAX, 1'b1,
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}},
			'{SET_ALL_MAX, 1'b1,
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_ALL_MAX, 1'b1, '{0, 0, 0, 0, 0, 0},
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_ALL_MIN, 1'b1,
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}},
			'{SET_ALL_MIN, 1'b1,
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
				'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}},
			'{SET_ALL_MIN, 1'b1, '{0, 0, 0, 0, 0, 0},
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}},
			'{SET_ALL_MIN, 1'b0, '{-3, 5, 1 << 20, 9, 70000, 1 << 21}, '0},
			'{SET_ZERO, 1'b1,
				'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX},
				'{0, 0, 0, 0, 0, 0}},
			'{SET_MIXED, 1'b0, '{-65536, -131072, 98304, 65536, 131072, 262144}, '0},
			'{SET_MIXED, 1'b0, '{327680, 12345, -1, -327680, -54321, 1}, '0},
			'{SET_MINUS_LSB, 1'b1, '{0, 0, 0, 1, 1, 1}, '{-4, -4, -4, -1, -1, -1}},
			'{SET_MINUS_LSB, 1'b0, '{1, 1, 1, 0, 0, 0}, '0}
		};

		// Reset is held from time zero and released on a clock edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// The block leaves reset with the identity matrix, so the first rows need no write.
		setting_now = SET_IDENTITY;
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].setting != setting_now) begin
				wait_drained();
				load_directed(directed_rows[i].setting);
				setting_now = directed_rows[i].setting;
			end
			send_box(directed_rows[i].stim);
			expected_boxes.push_back(directed_rows[i].typed ? directed_rows[i].want
				: transform_box(directed_rows[i].stim));
			pace_sender();
		end

		// Random phases. Each phase starts from an empty pipeline, so the sender also
		// pauses until every expected result has come back.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			load_random_matrix();
			repeat (ITEMS_PER_PHASE) begin
				b = random_box();
				send_box(b);
				expected_boxes.push_back(transform_box(b));
				pace_sender();
			end
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== affine_box_transform.f =====
+incdir+hdl
hdl/abt_pkg.sv
hdl/abt_cfg_regs.sv
hdl/abt_mul_stage.sv
hdl/abt_sum_stage.sv
hdl/affine_box_transform.sv
test/tb_top.sv
